// ----- sv/five_stage_pipelined_cpu_subset_defines.svh -----
// Assertion macros shared by the five-stage pipeline RTL
`ifndef FIVE_STAGE_PIPELINED_CPU_SUBSET_DEFINES_SVH
`define FIVE_STAGE_PIPELINED_CPU_SUBSET_DEFINES_SVH

// Condition that must hold at every clock edge outside reset
`define FSPC_ASSERT_NOW(label, cond, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (cond)) else $error(msg);

// Condition that must hold at the next clock edge after the trigger
`define FSPC_ASSERT_NEXT(label, trig, cond, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (trig) |=> (cond)) else $error(msg);

`endif

// ----- sv/fspc_pkg.sv -----
// Shared types, codes and helper functions of the five-stage pipeline
package fspc_pkg;

  localparam int MEM_WORDS_DEFAULT = 64;
  localparam int REG_COUNT         = 32;

  // Item modes
  localparam logic [1:0] MODE_TICK     = 2'd0;
  localparam logic [1:0] MODE_LOAD_MEM = 2'd1;
  localparam logic [1:0] MODE_LOAD_REG = 2'd2;

  // Opcodes
  localparam logic [5:0] OP_RTYPE = 6'd0;
  localparam logic [5:0] OP_J     = 6'd2;
  localparam logic [5:0] OP_BEQ   = 6'd4;
  localparam logic [5:0] OP_LW    = 6'd35;
  localparam logic [5:0] OP_SW    = 6'd43;

  // Main-control ALUOp field
  localparam logic [1:0] ALUOP_MEM   = 2'b00;
  localparam logic [1:0] ALUOP_BEQ   = 2'b01;
  localparam logic [1:0] ALUOP_RTYPE = 2'b10;

  // ALU operations
  localparam logic [2:0] ALU_AND = 3'd0;
  localparam logic [2:0] ALU_OR  = 3'd1;
  localparam logic [2:0] ALU_ADD = 3'd2;
  localparam logic [2:0] ALU_SUB = 3'd6;

  typedef struct packed {
    logic [1:0]  mode;
    logic [5:0]  load_index;
    logic [31:0] load_value;
  } item_t;

  typedef struct packed {
    logic [31:0] fetched_instruction;
    logic [31:0] program_counter;
    logic        writeback_enable;
    logic [4:0]  writeback_register;
    logic [31:0] writeback_value;
    logic        pipeline_idle;
  } result_t;

  // ID/EX register (read data lives in the register file's read registers)
  typedef struct packed {
    logic [31:0] instr;
    logic [31:0] next_pc;
    logic [31:0] imm;
    logic [4:0]  rt;
    logic [4:0]  rd;
    logic [1:0]  alu_op;
    logic        reg_dst;
    logic        alu_src;
    logic        branch;
    logic        mem_read;
    logic        mem_write;
    logic        mem_to_reg;
    logic        reg_write;
  } dx_t;

  // EX/MEM register
  typedef struct packed {
    logic [31:0] instr;
    logic [31:0] alu_res;
    logic [31:0] wdata;
    logic [4:0]  dest;
    logic        mem_read;
    logic        mem_write;
    logic        mem_to_reg;
    logic        reg_write;
  } xm_t;

  // MEM/WB register (load data lives in the memory's read register)
  typedef struct packed {
    logic [31:0] instr;
    logic [31:0] alu_res;
    logic [4:0]  dest;
    logic        mem_to_reg;
    logic        reg_write;
  } mw_t;

  // Textbook ALU control equations on ALUOp and funct[3:0]
  function automatic logic [2:0] alu_op_decode(input logic [1:0] alu_op,
                                               input logic [3:0] funct);
    logic [2:0] op;
    op[0] = alu_op[1] & (funct[0] | funct[3]);
    op[1] = ~alu_op[1] | ~funct[2];
    op[2] = alu_op[0] | (alu_op[1] & funct[1]);
    return op;
  endfunction

endpackage

// ----- sv/fspc_ram.sv -----
// One-write, two-read RAM with registered, write-first read data
module fspc_ram #(
  parameter int Depth = 64,
  parameter int Width = 32
) (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     wr_en,
  input  logic [$clog2(Depth)-1:0] wr_addr,
  input  logic [Width-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(Depth)-1:0] rd_addr_a,
  input  logic [$clog2(Depth)-1:0] rd_addr_b,
  output logic [Width-1:0]         rd_data_a,
  output logic [Width-1:0]         rd_data_b
);

  logic [Width-1:0] mem [Depth];

  // Write port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // Read ports; a write in the same cycle is seen by the read
  always_ff @(posedge clk) begin
    if (rst) begin
      rd_data_a <= '0;
      rd_data_b <= '0;
    end else if (rd_en) begin
      rd_data_a <= (wr_en && (wr_addr == rd_addr_a)) ? wr_data : mem[rd_addr_a];
      rd_data_b <= (wr_en && (wr_addr == rd_addr_b)) ? wr_data : mem[rd_addr_b];
    end
  end

endmodule

// ----- sv/fspc_alu.sv -----
// ALU control decode and ALU of the execute stage
module fspc_alu
  import fspc_pkg::*;
(
  input  logic [1:0]  alu_op,
  input  logic [3:0]  funct,
  input  logic [31:0] a,
  input  logic [31:0] b,
  input  logic [31:0] held,
  output logic [31:0] result,
  output logic        zero
);

  logic [2:0] op;

  assign op = alu_op_decode(alu_op, funct);

  // Unlisted operations keep the previous result and clear zero
  always_comb begin
    result = held;
    zero   = 1'b0;
    case (op)
      ALU_AND: result = a & b;
      ALU_OR:  result = a | b;
      ALU_ADD: result = a + b;
      ALU_SUB: begin
        result = a - b;
        zero   = (a == b);
      end
      default: result = held;
    endcase
  end

endmodule

// ----- sv/five_stage_pipelined_cpu_subset.sv -----
// Five-stage pipeline subset: item channel, result channel and stage registers
//
// Usage: items arrive on item/item_valid/item_ready. A tick item advances all
// five stages (WB, MEM, EX, ID, IF) of the modelled pipeline; a load item
// writes one word of memory or one register (none for a register index above
// 31) and reports zeros with the current idle flag. Each accepted item gives
// one result on result/result_valid/result_ready, in the cycle after its
// transfer. Throughput is one item per cycle while no result stalls: every
// stage update is a single register step, and the memory and register file
// are each read once per port per tick through registered read ports. A new
// item is taken in the same cycle the waiting result is taken; while a result
// stalls, item_ready is low. After reset the memory and register file are
// swept to zero, one entry per cycle; item_ready stays low meanwhile.
// MemoryWords must be a power of two (addresses wrap on the low bits).
`include "five_stage_pipelined_cpu_subset_defines.svh"

module five_stage_pipelined_cpu_subset
  import fspc_pkg::*;
#(
  parameter int MemoryWords = MEM_WORDS_DEFAULT
) (
  input  logic    clk,
  input  logic    rst,
  input  item_t   item,
  input  logic    item_valid,
  output logic    item_ready,
  output result_t result,
  output logic    result_valid,
  input  logic    result_ready
);

  localparam int MemAw  = $clog2(MemoryWords);
  localparam int RegAw  = $clog2(REG_COUNT);
  localparam int ClrLen = (MemoryWords > REG_COUNT) ? MemoryWords : REG_COUNT;
  localparam int ClrAw  = $clog2(ClrLen);

  // Control and stage registers
  logic             clearing;
  logic [ClrAw-1:0] clr_count;
  logic             res_tick;
  logic             wb_en_q;
  logic [4:0]       wb_reg_q;
  logic [31:0]      wb_val_q;
  dx_t              dx;
  xm_t              xm;
  mw_t              mw;
  logic [31:0]      fd_next_pc;
  logic [31:0]      fetch_addr;
  logic [31:0]      seq_addr;
  logic             jump_flag;
  logic [25:0]      jump_field;

  // Read registers inside the RAMs
  logic [31:0] fd_instr;
  logic [31:0] mw_rdata;
  logic [31:0] dx_rd1;
  logic [31:0] dx_rd2;

  // Next-state logic
  logic        item_xfer;
  logic        tick;
  logic        ld_mem;
  logic        ld_reg;
  logic [31:0] ld_idx_ext;
  logic [31:0] wb_val;
  logic [31:0] alu_b;
  logic [31:0] alu_res;
  logic        alu_zero;
  logic [31:0] branch_target;
  logic [31:0] jump_target;
  logic [31:0] fetch_next;
  logic [31:0] seq_next;
  logic [5:0]  opcode;
  logic        is_r;
  logic        is_lw;
  logic        is_sw;
  logic        is_beq;
  dx_t         dx_next;
  xm_t         xm_next;
  mw_t         mw_next;
  logic        idle;

  logic             rf_wr_en;
  logic [RegAw-1:0] rf_wr_addr;
  logic [31:0]      rf_wr_data;
  logic             mem_wr_en;
  logic [MemAw-1:0] mem_wr_addr;
  logic [31:0]      mem_wr_data;

  function automatic logic [31:0] fetch_addr_inc(input logic [31:0] addr);
    return addr + 32'd4;
  endfunction

  // Handshake
  assign item_ready = !clearing && (!result_valid || result_ready);
  assign item_xfer  = item_valid && item_ready;
  assign tick       = item_xfer && (item.mode == MODE_TICK);
  assign ld_mem     = item_xfer && (item.mode == MODE_LOAD_MEM);
  assign ld_reg     = item_xfer && (item.mode == MODE_LOAD_REG) && !item.load_index[5];
  assign ld_idx_ext = {26'd0, item.load_index};

  // WB: value written back this tick
  assign wb_val = mw.mem_to_reg ? mw_rdata : mw.alu_res;

  // Register file write port: clear sweep, writeback or load
  always_comb begin
    rf_wr_en   = 1'b0;
    rf_wr_addr = clr_count[RegAw-1:0];
    rf_wr_data = '0;
    if (clearing) begin
      rf_wr_en = 1'b1;
    end else if (tick && mw.reg_write) begin
      rf_wr_en   = 1'b1;
      rf_wr_addr = mw.dest;
      rf_wr_data = wb_val;
    end else if (ld_reg) begin
      rf_wr_en   = 1'b1;
      rf_wr_addr = item.load_index[RegAw-1:0];
      rf_wr_data = item.load_value;
    end
  end

  // Memory write port: clear sweep, store or load
  always_comb begin
    mem_wr_en   = 1'b0;
    mem_wr_addr = clr_count[MemAw-1:0];
    mem_wr_data = '0;
    if (clearing) begin
      mem_wr_en = 1'b1;
    end else if (tick && xm.mem_write) begin
      mem_wr_en   = 1'b1;
      mem_wr_addr = xm.alu_res[MemAw-1:0];
      mem_wr_data = xm.wdata;
    end else if (ld_mem) begin
      mem_wr_en   = 1'b1;
      mem_wr_addr = ld_idx_ext[MemAw-1:0];
      mem_wr_data = item.load_value;
    end
  end

  // MEM: pass EX/MEM on; load data comes from memory port B
  always_comb begin
    mw_next.instr      = xm.instr;
    mw_next.alu_res    = xm.alu_res;
    mw_next.dest       = xm.dest;
    mw_next.mem_to_reg = xm.mem_to_reg;
    mw_next.reg_write  = xm.reg_write;
  end

  // EX: ALU, branch target and fetch redirect
  assign alu_b = dx.alu_src ? dx.imm : dx_rd2;

  fspc_alu u_alu (
    .alu_op (dx.alu_op),
    .funct  (dx.imm[3:0]),
    .a      (dx_rd1),
    .b      (alu_b),
    .held   (xm.alu_res),
    .result (alu_res),
    .zero   (alu_zero)
  );

  assign branch_target = dx.next_pc + {dx.imm[29:0], 2'b00};
  assign jump_target   = {4'b0000, jump_field, 2'b00};

  always_comb begin
    if (jump_flag) begin
      fetch_next = jump_target;
    end else if (dx.branch && alu_zero) begin
      fetch_next = branch_target;
    end else begin
      fetch_next = seq_addr;
    end
  end

  always_comb begin
    xm_next.instr      = dx.instr;
    xm_next.alu_res    = alu_res;
    xm_next.wdata      = dx_rd2;
    xm_next.dest       = dx.reg_dst ? dx.rd : dx.rt;
    xm_next.mem_read   = dx.mem_read;
    xm_next.mem_write  = dx.mem_write;
    xm_next.mem_to_reg = dx.mem_to_reg;
    xm_next.reg_write  = dx.reg_write;
  end

  // ID: main control decode
  assign opcode = fd_instr[31:26];
  assign is_r   = (opcode == OP_RTYPE);
  assign is_lw  = (opcode == OP_LW);
  assign is_sw  = (opcode == OP_SW);
  assign is_beq = (opcode == OP_BEQ);

  always_comb begin
    dx_next.instr      = fd_instr;
    dx_next.next_pc    = fd_next_pc;
    dx_next.imm        = {{16{fd_instr[15]}}, fd_instr[15:0]};
    dx_next.rt         = fd_instr[20:16];
    dx_next.rd         = fd_instr[15:11];
    dx_next.reg_dst    = is_r;
    dx_next.alu_src    = is_lw || is_sw;
    dx_next.branch     = is_beq;
    dx_next.mem_read   = is_lw;
    dx_next.mem_write  = is_sw;
    dx_next.mem_to_reg = is_lw;
    dx_next.reg_write  = is_r || is_lw;
    if (is_r) begin
      dx_next.alu_op = ALUOP_RTYPE;
    end else if (is_beq) begin
      dx_next.alu_op = ALUOP_BEQ;
    end else begin
      dx_next.alu_op = ALUOP_MEM;
    end
  end

  // IF: sequential address
  assign seq_next = fetch_addr_inc(fetch_next);

  // Register file; reads feed the ID/EX operands
  fspc_ram #(
    .Depth (REG_COUNT),
    .Width (32)
  ) u_regfile (
    .clk       (clk),
    .rst       (rst),
    .wr_en     (rf_wr_en),
    .wr_addr   (rf_wr_addr),
    .wr_data   (rf_wr_data),
    .rd_en     (tick),
    .rd_addr_a (fd_instr[25:21]),
    .rd_addr_b (fd_instr[20:16]),
    .rd_data_a (dx_rd1),
    .rd_data_b (dx_rd2)
  );

  // Word memory; port A fetches, port B serves loads
  fspc_ram #(
    .Depth (MemoryWords),
    .Width (32)
  ) u_memory (
    .clk       (clk),
    .rst       (rst),
    .wr_en     (mem_wr_en),
    .wr_addr   (mem_wr_addr),
    .wr_data   (mem_wr_data),
    .rd_en     (tick),
    .rd_addr_a (fetch_next[MemAw-1:0]),
    .rd_addr_b (xm.alu_res[MemAw-1:0]),
    .rd_data_a (fd_instr),
    .rd_data_b (mw_rdata)
  );

  // Stage registers, clear sweep and result register
  always_ff @(posedge clk) begin
    if (rst) begin
      clearing     <= 1'b1;
      clr_count    <= '0;
      result_valid <= 1'b0;
      res_tick     <= 1'b0;
      wb_en_q      <= 1'b0;
      wb_reg_q     <= '0;
      wb_val_q     <= '0;
      dx           <= '0;
      xm           <= '0;
      mw           <= '0;
      fd_next_pc   <= '0;
      fetch_addr   <= '0;
      seq_addr     <= '0;
      jump_flag    <= 1'b0;
      jump_field   <= '0;
    end else begin
      if (clearing) begin
        clr_count <= clr_count + 1'b1;
        if (clr_count == ClrAw'(ClrLen - 1)) begin
          clearing <= 1'b0;
        end
      end
      if (item_xfer) begin
        result_valid <= 1'b1;
      end else if (result_ready) begin
        result_valid <= 1'b0;
      end
      if (item_xfer) begin
        res_tick <= tick;
        wb_en_q  <= tick && mw.reg_write;
        wb_reg_q <= (tick && mw.reg_write) ? mw.dest : 5'd0;
        wb_val_q <= (tick && mw.reg_write) ? wb_val : 32'd0;
      end
      if (tick) begin
        dx         <= dx_next;
        xm         <= xm_next;
        mw         <= mw_next;
        fd_next_pc <= seq_next;
        fetch_addr <= fetch_next;
        seq_addr   <= seq_next;
        jump_flag  <= (opcode == OP_J);
        jump_field <= fd_instr[25:0];
      end
    end
  end

  // Idle: no stage holds an instruction with a visible effect
  assign idle = (fd_instr == 32'd0)
             && ((dx.instr == 32'd0)
                 || (!dx.reg_write && !dx.mem_write && !dx.mem_read))
             && ((xm.instr == 32'd0)
                 || (!xm.reg_write && !xm.mem_write && !xm.mem_read))
             && ((mw.instr == 32'd0) || !mw.reg_write);

  // Result fields; load results carry zeros apart from the idle flag
  always_comb begin
    result.fetched_instruction = res_tick ? fd_instr : 32'd0;
    result.program_counter     = res_tick ? fetch_addr : 32'd0;
    result.writeback_enable    = wb_en_q;
    result.writeback_register  = wb_reg_q;
    result.writeback_value     = wb_val_q;
    result.pipeline_idle       = idle;
  end

  // Assertions
  `FSPC_ASSERT_NOW(a_no_take_while_clearing, !(clearing && item_ready), "item taken during clear sweep")
  `FSPC_ASSERT_NEXT(a_load_gives_zero_tick_fields, item_valid && item_ready && (item.mode != MODE_TICK), result_valid && !result.writeback_enable && (result.program_counter == 32'd0), "load transfer reported tick fields")
  `FSPC_ASSERT_NOW(a_pc_word_aligned, !result_valid || (result.program_counter[1:0] == 2'b00), "fetch address not word aligned")
  `FSPC_ASSERT_NEXT(a_jump_redirects_fetch, tick && jump_flag, fetch_addr == $past(jump_target), "pending jump did not redirect the fetch")

endmodule
